FILE: hw/rtl/escaped_frame_receiver_core_defines.svh
// ----------------------------------------------------------------------------
// escaped frame receiver assertion macros
// shared property wrappers for the port checker, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_CORE_DEFINES_SVH

// plain property, disabled while reset is low
`define EFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// a stalled word keeps the given signal stable in the next cycle
`define EFR_ASSERT_STALL(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

FILE: hw/rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// types and constants shared by the escaped frame receiver modules
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned CHECK_W   = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LITERAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd3;

  localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'd190;
  localparam logic [BYTE_W-1:0] LITERAL_RST = 8'd85;
  localparam logic [BYTE_W-1:0] START_RST   = 8'd239;
  localparam logic [BYTE_W-1:0] END_RST     = 8'd229;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_FAIL  = 2'd2,
    KIND_ABORT = 2'd3
  } kind_e;

  // classified word handed from front to back
  typedef enum logic [1:0] {
    TOK_BYTE  = 2'd0,
    TOK_START = 2'd1,
    TOK_END   = 2'd2,
    TOK_BAD   = 2'd3
  } tok_e;

  typedef struct packed {
    tok_e              op;
    logic [BYTE_W-1:0] data;
  } tok_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_TYPE = 3'd1,
    MODE_SEQ0 = 3'd2,
    MODE_SEQ1 = 3'd3,
    MODE_CHAN = 3'd4,
    MODE_DATA = 3'd5,
    MODE_CK1  = 3'd6,
    MODE_CK2  = 3'd7
  } mode_e;

endpackage

FILE: hw/rtl/efr_rx_if.sv
// ----------------------------------------------------------------------------
// efr_rx_if
// raw received byte channel
// ----------------------------------------------------------------------------
interface efr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/efr_res_if.sv
// ----------------------------------------------------------------------------
// efr_res_if
// result channel: payload bytes and frame status words
// ----------------------------------------------------------------------------
interface efr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_kind;
  logic [15:0] sequence_res;
  logic [7:0]  channel_id;
  logic [10:0] payload_length;
  logic [15:0] computed_check;

  modport source (output valid, output kind, output data_byte, output frame_kind,
                  output sequence_res, output channel_id, output payload_length,
                  output computed_check, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_kind,
                  input sequence_res, input channel_id, input payload_length,
                  input computed_check, output ready);
endinterface

FILE: hw/rtl/efr_cfg_if.sv
// ----------------------------------------------------------------------------
// efr_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface efr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: hw/rtl/efr_front.sv
// ----------------------------------------------------------------------------
// efr_front
// holds the escape codes, strips escape sequences and classifies each word
// ----------------------------------------------------------------------------
module efr_front
  import efr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  efr_rx_if.sink  rx_i,
  efr_cfg_if.sink cfg_i,
  output logic  tok_valid_o,
  output tok_t  tok_o,
  input  logic  tok_ready_i
);

  logic [BYTE_W-1:0] escape_q, literal_q, start_q, end_q;
  logic              esc_q, esc_d;
  logic              rx_acc;
  logic [BYTE_W-1:0] c;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q  <= ESCAPE_RST;
      literal_q <= LITERAL_RST;
      start_q   <= START_RST;
      end_q     <= END_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ESCAPE:  escape_q  <= cfg_i.wdata;
        CFG_LITERAL: literal_q <= cfg_i.wdata;
        CFG_START:   start_q   <= cfg_i.wdata;
        CFG_END:     end_q     <= cfg_i.wdata;
        default: begin
        end
      endcase
    end
  end

  assign c           = rx_i.rx_byte;
  assign rx_i.ready  = tok_ready_i;
  assign rx_acc      = rx_i.valid && tok_ready_i;
  // a lone escape byte is swallowed, the code byte after it makes the word
  assign tok_valid_o = rx_i.valid && (esc_q || (c != escape_q));

  always_comb begin
    tok_o.op   = TOK_BYTE;
    tok_o.data = c;
    esc_d      = esc_q;
    if (esc_q) begin
      // literal is tested before start, start before end
      if (c == literal_q) begin
        tok_o.data = escape_q;
      end else if (c == start_q) begin
        tok_o.op = TOK_START;
      end else if (c == end_q) begin
        tok_o.op = TOK_END;
      end else begin
        tok_o.op = TOK_BAD;
      end
      if (rx_acc) begin
        esc_d = 1'b0;
      end
    end else if (rx_acc && (c == escape_q)) begin
      esc_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

FILE: hw/rtl/efr_fifo.sv
// ----------------------------------------------------------------------------
// efr_fifo
// two-entry queue of classified words between front and back
// ----------------------------------------------------------------------------
module efr_fifo
  import efr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  tok_t push_tok_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output tok_t pop_tok_o
);

  tok_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_tok_o    = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hw/rtl/efr_back.sv
// ----------------------------------------------------------------------------
// efr_back
// frame parser: header capture, fletcher-16 sums, length check, result register
// ----------------------------------------------------------------------------
module efr_back
  import efr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tok_valid_i,
  output logic tok_ready_o,
  input  tok_t tok_i,
  efr_res_if.source res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

  function automatic logic [8:0] fold(input logic [10:0] s);
    return 9'(s[7:0]) + 9'(s[10:8]);
  endfunction

  mode_e             mode_q, mode_d;
  logic [8:0]        sf_q, sf_d, ss_q, ss_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [BYTE_W-1:0] type_q, type_d, chan_q, chan_d, cklo_q, cklo_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [CHECK_W-1:0] final_q, final_d;
  logic              take;

  logic              emit;
  kind_e             emit_kind;
  logic [BYTE_W-1:0] emit_data;
  logic              busy;
  logic [9:0]        sf_raw;
  logic [10:0]       ss_raw;
  logic [8:0]        sf_sum, ss_sum, f1, f2;
  logic [LEN_W+CNT_W-1:0] cnt_ext;

  logic               res_valid_q, res_valid_d;
  logic [KIND_W-1:0]  kind_q;
  logic [BYTE_W-1:0]  data_q, fkind_q, fchan_q;
  logic [SEQ_W-1:0]   fseq_q;
  logic [LEN_W-1:0]   len_q;
  logic [CHECK_W-1:0] check_q;

  assign tok_ready_o = !res_valid_q || res_o.ready;
  assign take        = tok_valid_i && tok_ready_o;
  assign busy        = (mode_q != MODE_IDLE);
  assign cnt_inc     = cnt_q + CNT_W'(1);
  assign cnt_ext     = {{LEN_W{1'b0}}, cnt_q};

  // one fletcher step on the incoming byte
  assign sf_raw = 10'(sf_q) + 10'(tok_i.data);
  assign ss_raw = 11'(ss_q) + 11'(sf_raw);
  assign sf_sum = fold(11'(sf_raw));
  assign ss_sum = fold(ss_raw);
  assign f1     = fold(11'(sf_q));
  assign f2     = fold(11'(ss_q));

  always_comb begin
    mode_d    = mode_q;
    sf_d      = sf_q;
    ss_d      = ss_q;
    cnt_d     = cnt_q;
    type_d    = type_q;
    seq_d     = seq_q;
    chan_d    = chan_q;
    cklo_d    = cklo_q;
    final_d   = final_q;
    emit      = 1'b0;
    emit_kind = KIND_DATA;
    emit_data = '0;
    if (take) begin
      case (tok_i.op)
        TOK_START: begin
          mode_d    = MODE_TYPE;
          cnt_d     = '0;
          sf_d      = 9'd255;
          ss_d      = 9'd255;
          emit      = busy;
          emit_kind = KIND_ABORT;
        end
        TOK_END: begin
          if (mode_q == MODE_DATA) begin
            final_d = {f2[7:0], 8'h00} | {7'b0, f1};
            mode_d  = MODE_CK1;
          end else begin
            mode_d    = MODE_IDLE;
            cnt_d     = '0;
            emit      = busy;
            emit_kind = KIND_ABORT;
          end
        end
        TOK_BAD: begin
          mode_d    = MODE_IDLE;
          cnt_d     = '0;
          emit      = busy;
          emit_kind = KIND_ABORT;
        end
        default: begin
          case (mode_q)
            MODE_TYPE: begin
              type_d = tok_i.data;
              sf_d   = sf_sum;
              ss_d   = ss_sum;
              mode_d = MODE_SEQ0;
            end
            MODE_SEQ0: begin
              seq_d  = {8'h00, tok_i.data};
              sf_d   = sf_sum;
              ss_d   = ss_sum;
              mode_d = MODE_SEQ1;
            end
            MODE_SEQ1: begin
              seq_d  = {tok_i.data, seq_q[7:0]};
              sf_d   = sf_sum;
              ss_d   = ss_sum;
              mode_d = MODE_CHAN;
            end
            MODE_CHAN: begin
              chan_d = tok_i.data;
              sf_d   = sf_sum;
              ss_d   = ss_sum;
              mode_d = MODE_DATA;
            end
            MODE_DATA: begin
              sf_d = sf_sum;
              ss_d = ss_sum;
              emit = 1'b1;
              // the byte that reaches the limit turns into an abort
              if (cnt_inc >= CNT_W'(MAX_PAYLOAD)) begin
                mode_d    = MODE_IDLE;
                cnt_d     = '0;
                emit_kind = KIND_ABORT;
              end else begin
                cnt_d     = cnt_inc;
                emit_data = tok_i.data;
              end
            end
            MODE_CK1: begin
              cklo_d = tok_i.data;
              mode_d = MODE_CK2;
            end
            MODE_CK2: begin
              emit      = 1'b1;
              emit_kind = ({tok_i.data, cklo_q} == final_q) ? KIND_GOOD : KIND_FAIL;
              mode_d    = MODE_IDLE;
              cnt_d     = '0;
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (take) begin
      res_valid_d = emit;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sf_q    <= sf_d;
    ss_q    <= ss_d;
    type_q  <= type_d;
    seq_q   <= seq_d;
    chan_q  <= chan_d;
    cklo_q  <= cklo_d;
    final_q <= final_d;
    if (take && emit) begin
      kind_q  <= emit_kind;
      data_q  <= emit_data;
      if ((emit_kind == KIND_GOOD) || (emit_kind == KIND_FAIL)) begin
        fkind_q <= type_q;
        fseq_q  <= seq_q;
        fchan_q <= chan_q;
        len_q   <= cnt_ext[LEN_W-1:0];
        check_q <= final_q;
      end else begin
        fkind_q <= '0;
        fseq_q  <= '0;
        fchan_q <= '0;
        len_q   <= '0;
        check_q <= '0;
      end
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.kind           = kind_q;
  assign res_o.data_byte      = data_q;
  assign res_o.frame_kind     = fkind_q;
  assign res_o.sequence_res   = fseq_q;
  assign res_o.channel_id     = fchan_q;
  assign res_o.payload_length = len_q;
  assign res_o.computed_check = check_q;

endmodule

FILE: hw/rtl/escaped_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_core
// byte-stuffed frame receiver with fletcher-16 check
// ----------------------------------------------------------------------------
// usage:
//   rx_i carries one raw serial byte per word. res_o gives one word per
//   payload byte (kind data) and one status word per frame: good, checksum
//   fail or abort. cfg_i writes the escape, literal, start and end codes
//   (index 0..3), always ready; write only while the receiver is idle.
//   path: a byte that yields a result is registered in the queue and then in
//   the output register before it shows on res_o (front classifies into a
//   two-entry queue, back parses from the queue into the output register).
//   escape bytes and header bytes yield nothing.
//   throughput: one byte per cycle while res_o is ready; the output register
//   accepts a new word on the cycle the old one is taken.
//   stall: when res_o is not ready with a word waiting, the back end holds,
//   the queue fills and rx_i.ready drops after two more words.
//   reset: codes return to 190/85/239/229, receiver waits for a frame start,
//   queue and output register are empty.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_core
  import efr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  efr_rx_if.sink    rx_i,
  efr_cfg_if.sink   cfg_i,
  efr_res_if.source res_o
);

  logic fr_valid, fr_ready, bk_valid, bk_ready;
  tok_t fr_tok, bk_tok;

  efr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cfg_i       (cfg_i),
    .tok_valid_o (fr_valid),
    .tok_o       (fr_tok),
    .tok_ready_i (fr_ready)
  );

  efr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_tok_i   (fr_tok),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_tok_o    (bk_tok)
  );

  efr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (bk_valid),
    .tok_ready_o (bk_ready),
    .tok_i       (bk_tok),
    .res_o       (res_o)
  );

endmodule

FILE: hw/rtl/efr_checker.sv
// ----------------------------------------------------------------------------
// efr_checker
// port-level properties of the escaped frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_core_defines.svh"

module efr_checker
  import efr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  res_kind_i,
  input logic [7:0]  res_data_byte_i,
  input logic [10:0] res_length_i,
  input logic [15:0] res_check_i
);

  `EFR_ASSERT_STALL(a_res_hold, res_valid_i, res_ready_i, res_valid_i, "result word dropped")
  `EFR_ASSERT(a_data_zero, (res_valid_i && res_kind_i != KIND_DATA) |-> res_data_byte_i == 8'd0, "data byte set on status word")
  `EFR_ASSERT(a_len_zero, (res_valid_i && (res_kind_i == KIND_DATA || res_kind_i == KIND_ABORT)) |-> (res_length_i == 11'd0 && res_check_i == 16'd0), "frame fields set on data or abort word")
  `EFR_ASSERT(a_len_max, (res_valid_i && (res_kind_i == KIND_GOOD || res_kind_i == KIND_FAIL)) |-> 32'(res_length_i) < MAX_PAYLOAD || MAX_PAYLOAD > 2047, "frame length at or over limit")

endmodule

bind escaped_frame_receiver_core efr_checker #(
  .MAX_PAYLOAD (MAX_PAYLOAD)
) u_efr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_kind_i      (res_o.kind),
  .res_data_byte_i (res_o.data_byte),
  .res_length_i    (res_o.payload_length),
  .res_check_i     (res_o.computed_check)
);
